>>> sv/cftp_pkg.sv
// Shared types and fixed widths for the circle-from-three-points pipeline.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package cftp_pkg;

    localparam int OUT_W    = 32;
    localparam int RAD_W    = 32;
    localparam int SQ_W     = 64;
    localparam int SQ_STEPS = SQ_W / 2;

    typedef struct packed {
        logic signed [OUT_W-1:0] cx;
        logic signed [OUT_W-1:0] cy;
        logic                    sat_c;
        logic                    big_r;
        logic                    coll;
    } t_fin_tag;

    localparam int FIN_TAG_W = $bits(t_fin_tag);

endpackage

>>> sv/cftp_if.sv
// Valid/ready channel interfaces for the point triple input and the circle result.
// Depends on cftp_pkg for the result widths.
`timescale 1ns / 1ps

interface cftp_in_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_a_x;
    logic [COORD_BITS-1:0] point_a_y;
    logic [COORD_BITS-1:0] point_b_x;
    logic [COORD_BITS-1:0] point_b_y;
    logic [COORD_BITS-1:0] point_c_x;
    logic [COORD_BITS-1:0] point_c_y;

    modport source (
        output valid, point_a_x, point_a_y, point_b_x, point_b_y, point_c_x, point_c_y,
        input  ready
    );
    modport sink (
        input  valid, point_a_x, point_a_y, point_b_x, point_b_y, point_c_x, point_c_y,
        output ready
    );
endinterface

interface cftp_out_if
    import cftp_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] center_x;
    logic signed [OUT_W-1:0] center_y;
    logic [RAD_W-1:0]        circle_radius;
    logic                    collinear;
    logic                    saturated;

    modport source (
        output valid, center_x, center_y, circle_radius, collinear, saturated,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, circle_radius, collinear, saturated,
        output ready
    );
endinterface

>>> sv/cftp_front.sv
// Front end: point offsets, squared norms, determinant and the two numerators,
// reduced to magnitudes and signs over six register stages. No dependencies.
`timescale 1ns / 1ps

module cftp_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [COORD_BITS-1:0]     i_ax,
    input  logic [COORD_BITS-1:0]     i_ay,
    input  logic [COORD_BITS-1:0]     i_bx,
    input  logic [COORD_BITS-1:0]     i_by,
    input  logic [COORD_BITS-1:0]     i_cx,
    input  logic [COORD_BITS-1:0]     i_cy,
    output logic                      o_valid,
    output logic [3*COORD_BITS+1:0]   o_nmag_x,
    output logic [3*COORD_BITS+1:0]   o_nmag_y,
    output logic [2*COORD_BITS+1:0]   o_dmag,
    output logic                      o_neg_x,
    output logic                      o_neg_y,
    output logic                      o_coll,
    output logic [COORD_BITS-1:0]     o_ax,
    output logic [COORD_BITS-1:0]     o_ay
);

    localparam int C    = COORD_BITS;
    localparam int D_W  = C + 1;
    localparam int P_W  = 2 * C + 2;
    localparam int E_W  = 2 * C + 3;
    localparam int T_W  = 3 * C + 3;
    localparam int NM_W = 3 * C + 2;
    localparam int DM_W = 2 * C + 2;
    localparam int NSTG = 6;

    logic [NSTG-1:0] r_vld;

    logic [C-1:0]            r_s1_ax, r_s1_ay;
    logic signed [D_W-1:0]   r_s1_dxb, r_s1_dyb, r_s1_dxc, r_s1_dyc;

    logic [C-1:0]            r_s2_ax, r_s2_ay;
    logic signed [D_W-1:0]   r_s2_dxb, r_s2_dyb, r_s2_dxc, r_s2_dyc;
    logic signed [P_W-1:0]   r_s2_xb2, r_s2_yb2, r_s2_xc2, r_s2_yc2, r_s2_p1, r_s2_p2;

    logic [C-1:0]            r_s3_ax, r_s3_ay;
    logic signed [D_W-1:0]   r_s3_dxb, r_s3_dyb, r_s3_dxc, r_s3_dyc;
    logic signed [P_W-1:0]   r_s3_sb, r_s3_sc;
    logic signed [E_W-1:0]   r_s3_den;

    logic [C-1:0]            r_s4_ax, r_s4_ay;
    logic signed [T_W-1:0]   r_s4_t1, r_s4_t2, r_s4_t3, r_s4_t4;
    logic signed [E_W-1:0]   r_s4_den;

    logic [C-1:0]            r_s5_ax, r_s5_ay;
    logic signed [T_W-1:0]   r_s5_nx, r_s5_ny;
    logic signed [E_W-1:0]   r_s5_den;

    logic [NM_W-1:0]         r_s6_nmx, r_s6_nmy;
    logic [DM_W-1:0]         r_s6_dmag;
    logic                    r_s6_negx, r_s6_negy, r_s6_coll;
    logic [C-1:0]            r_s6_ax, r_s6_ay;

    logic signed [T_W-1:0]   n_negnx, n_negny;
    logic signed [E_W-1:0]   n_negden;

    assign n_negnx  = -r_s5_nx;
    assign n_negny  = -r_s5_ny;
    assign n_negden = -r_s5_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_ax  <= i_ax;
            r_s1_ay  <= i_ay;
            r_s1_dxb <= D_W'(i_bx) - D_W'(i_ax);
            r_s1_dyb <= D_W'(i_by) - D_W'(i_ay);
            r_s1_dxc <= D_W'(i_cx) - D_W'(i_ax);
            r_s1_dyc <= D_W'(i_cy) - D_W'(i_ay);

            r_s2_ax  <= r_s1_ax;
            r_s2_ay  <= r_s1_ay;
            r_s2_dxb <= r_s1_dxb;
            r_s2_dyb <= r_s1_dyb;
            r_s2_dxc <= r_s1_dxc;
            r_s2_dyc <= r_s1_dyc;
            r_s2_xb2 <= r_s1_dxb * r_s1_dxb;
            r_s2_yb2 <= r_s1_dyb * r_s1_dyb;
            r_s2_xc2 <= r_s1_dxc * r_s1_dxc;
            r_s2_yc2 <= r_s1_dyc * r_s1_dyc;
            r_s2_p1  <= r_s1_dxb * r_s1_dyc;
            r_s2_p2  <= r_s1_dxc * r_s1_dyb;

            r_s3_ax  <= r_s2_ax;
            r_s3_ay  <= r_s2_ay;
            r_s3_dxb <= r_s2_dxb;
            r_s3_dyb <= r_s2_dyb;
            r_s3_dxc <= r_s2_dxc;
            r_s3_dyc <= r_s2_dyc;
            r_s3_sb  <= r_s2_xb2 + r_s2_yb2;
            r_s3_sc  <= r_s2_xc2 + r_s2_yc2;
            r_s3_den <= (r_s2_p1 - r_s2_p2) <<< 1;

            r_s4_ax  <= r_s3_ax;
            r_s4_ay  <= r_s3_ay;
            r_s4_den <= r_s3_den;
            r_s4_t1  <= r_s3_sb * r_s3_dyc;
            r_s4_t2  <= r_s3_sc * r_s3_dyb;
            r_s4_t3  <= r_s3_sc * r_s3_dxb;
            r_s4_t4  <= r_s3_sb * r_s3_dxc;

            r_s5_ax  <= r_s4_ax;
            r_s5_ay  <= r_s4_ay;
            r_s5_den <= r_s4_den;
            r_s5_nx  <= r_s4_t1 - r_s4_t2;
            r_s5_ny  <= r_s4_t3 - r_s4_t4;

            r_s6_ax   <= r_s5_ax;
            r_s6_ay   <= r_s5_ay;
            r_s6_nmx  <= r_s5_nx[T_W-1] ? n_negnx[NM_W-1:0] : r_s5_nx[NM_W-1:0];
            r_s6_nmy  <= r_s5_ny[T_W-1] ? n_negny[NM_W-1:0] : r_s5_ny[NM_W-1:0];
            r_s6_dmag <= r_s5_den[E_W-1] ? n_negden[DM_W-1:0] : r_s5_den[DM_W-1:0];
            r_s6_negx <= r_s5_nx[T_W-1] ^ r_s5_den[E_W-1];
            r_s6_negy <= r_s5_ny[T_W-1] ^ r_s5_den[E_W-1];
            r_s6_coll <= (r_s5_den == '0);
        end
    end

    assign o_valid  = r_vld[NSTG-1];
    assign o_nmag_x = r_s6_nmx;
    assign o_nmag_y = r_s6_nmy;
    assign o_dmag   = r_s6_dmag;
    assign o_neg_x  = r_s6_negx;
    assign o_neg_y  = r_s6_negy;
    assign o_coll   = r_s6_coll;
    assign o_ax     = r_s6_ax;
    assign o_ay     = r_s6_ay;

endmodule

>>> sv/cftp_div.sv
// Pipelined restoring divider, two dividends over one shared divisor,
// one quotient bit per register stage. No dependencies.
`timescale 1ns / 1ps

module cftp_div #(
    parameter int Q_W   = 43,
    parameter int D_W   = 26,
    parameter int TAG_W = 27
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [Q_W-1:0]   i_num_x,
    input  logic [Q_W-1:0]   i_num_y,
    input  logic [D_W-1:0]   i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [Q_W-1:0]   o_quo_x,
    output logic [Q_W-1:0]   o_quo_y,
    output logic [TAG_W-1:0] o_tag
);

    logic             r_vld [Q_W];
    logic [Q_W-1:0]   r_dq_x [Q_W];
    logic [Q_W-1:0]   r_dq_y [Q_W];
    logic [D_W-1:0]   r_rem_x [Q_W];
    logic [D_W-1:0]   r_rem_y [Q_W];
    logic [D_W-1:0]   r_den [Q_W];
    logic [TAG_W-1:0] r_tag [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic             w_vld;
        logic [Q_W-1:0]   w_dq_x, w_dq_y;
        logic [D_W-1:0]   w_rem_x, w_rem_y, w_den;
        logic [TAG_W-1:0] w_tag;
        logic [D_W:0]     w_t_x, w_t_y, w_d_x, w_d_y;
        logic             w_ge_x, w_ge_y;

        if (k == 0) begin : g_head
            assign w_vld   = i_valid;
            assign w_dq_x  = i_num_x;
            assign w_dq_y  = i_num_y;
            assign w_rem_x = '0;
            assign w_rem_y = '0;
            assign w_den   = i_den;
            assign w_tag   = i_tag;
        end else begin : g_body
            assign w_vld   = r_vld[k-1];
            assign w_dq_x  = r_dq_x[k-1];
            assign w_dq_y  = r_dq_y[k-1];
            assign w_rem_x = r_rem_x[k-1];
            assign w_rem_y = r_rem_y[k-1];
            assign w_den   = r_den[k-1];
            assign w_tag   = r_tag[k-1];
        end

        assign w_t_x  = {w_rem_x, w_dq_x[Q_W-1]};
        assign w_t_y  = {w_rem_y, w_dq_y[Q_W-1]};
        assign w_d_x  = w_t_x - {1'b0, w_den};
        assign w_d_y  = w_t_y - {1'b0, w_den};
        assign w_ge_x = (w_t_x >= {1'b0, w_den});
        assign w_ge_y = (w_t_y >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dq_x[k]  <= {w_dq_x[Q_W-2:0], w_ge_x};
                r_dq_y[k]  <= {w_dq_y[Q_W-2:0], w_ge_y};
                r_rem_x[k] <= w_ge_x ? w_d_x[D_W-1:0] : w_t_x[D_W-1:0];
                r_rem_y[k] <= w_ge_y ? w_d_y[D_W-1:0] : w_t_y[D_W-1:0];
                r_den[k]   <= w_den;
                r_tag[k]   <= w_tag;
            end
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quo_x = r_dq_x[Q_W-1];
    assign o_quo_y = r_dq_y[Q_W-1];
    assign o_tag   = r_tag[Q_W-1];

endmodule

>>> sv/cftp_sqrt.sv
// Pipelined integer square root of a 64-bit value, one result bit per stage,
// returning the floor root and the remainder. Depends on cftp_pkg.
`timescale 1ns / 1ps

module cftp_sqrt
    import cftp_pkg::*;
#(
    parameter int TAG_W = 67
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [SQ_W-1:0]  i_val,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [RAD_W-1:0] o_root,
    output logic [SQ_W-1:0]  o_rem,
    output logic [TAG_W-1:0] o_tag
);

    logic             r_vld [SQ_STEPS];
    logic [SQ_W-1:0]  r_v [SQ_STEPS];
    logic [SQ_W-1:0]  r_res [SQ_STEPS];
    logic [TAG_W-1:0] r_tag [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);

        logic             w_vld;
        logic [SQ_W-1:0]  w_v, w_res, w_trial;
        logic [TAG_W-1:0] w_tag;
        logic             w_ge;

        if (k == 0) begin : g_head
            assign w_vld = i_valid;
            assign w_v   = i_val;
            assign w_res = '0;
            assign w_tag = i_tag;
        end else begin : g_body
            assign w_vld = r_vld[k-1];
            assign w_v   = r_v[k-1];
            assign w_res = r_res[k-1];
            assign w_tag = r_tag[k-1];
        end

        assign w_trial = w_res + BIT;
        assign w_ge    = (w_v >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[k]   <= w_ge ? w_v - w_trial : w_v;
                r_res[k] <= w_ge ? (w_res >> 1) + BIT : w_res >> 1;
                r_tag[k] <= w_tag;
            end
        end
    end

    assign o_valid = r_vld[SQ_STEPS-1];
    assign o_root  = r_res[SQ_STEPS-1][RAD_W-1:0];
    assign o_rem   = r_v[SQ_STEPS-1];
    assign o_tag   = r_tag[SQ_STEPS-1];

endmodule

>>> sv/circle_from_three_points.sv
// Circle through three pixel points: fixed-point center and radius with
// saturation and a collinear flag. The input channel i_pts carries the three
// points; each accepted transaction yields exactly one transaction on o_circ.
// The pipeline is six front stages with the multipliers, one divider stage per
// quotient bit (3*COORD_BITS + FRAC_BITS + 3 of them), three rounding and
// clipping stages, 32 square-root stages and the output register. Throughput
// is one transaction per cycle unless o_circ stalls. Every stage moves together:
// when o_circ holds a result that is not taken, the whole pipeline and i_pts.ready
// stall, and nothing is lost or repeated. With o_circ empty or taken, i_pts.ready
// is high. Reset clears all valid bits, so the block is empty and ready in the
// first cycle after reset.
// Depends on cftp_pkg, cftp_if, cftp_front, cftp_div and cftp_sqrt.
`timescale 1ns / 1ps

module circle_from_three_points
    import cftp_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cftp_in_if.sink    i_pts,
    cftp_out_if.source o_circ
);

    localparam int C     = COORD_BITS;
    localparam int NM_W  = 3 * C + 2;
    localparam int DM_W  = 2 * C + 2;
    localparam int QW    = NM_W + FRAC_BITS + 1;
    localparam int DTAG  = 2 * C + 3;
    localparam int CE_W  = (QW + 2 > 34) ? QW + 2 : 34;
    localparam int M_W   = (QW > 33) ? QW : 33;
    localparam logic signed [CE_W-1:0] C_MAX = CE_W'(32'h7fff_ffff);
    localparam logic signed [CE_W-1:0] C_MIN = ~C_MAX;

    logic w_en;

    logic            f_vld, f_negx, f_negy, f_coll;
    logic [NM_W-1:0] f_nmx, f_nmy;
    logic [DM_W-1:0] f_dmag;
    logic [C-1:0]    f_ax, f_ay;

    logic            d_vld;
    logic [QW-1:0]   d_qx, d_qy;
    logic [DTAG-1:0] d_tag;
    logic [C-1:0]    d_ax, d_ay;
    logic            d_negx, d_negy, d_coll;

    assign w_en        = !o_circ.valid || o_circ.ready;
    assign i_pts.ready = w_en;

    cftp_front #(.COORD_BITS(C)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_pts.valid),
        .i_ax     (i_pts.point_a_x),
        .i_ay     (i_pts.point_a_y),
        .i_bx     (i_pts.point_b_x),
        .i_by     (i_pts.point_b_y),
        .i_cx     (i_pts.point_c_x),
        .i_cy     (i_pts.point_c_y),
        .o_valid  (f_vld),
        .o_nmag_x (f_nmx),
        .o_nmag_y (f_nmy),
        .o_dmag   (f_dmag),
        .o_neg_x  (f_negx),
        .o_neg_y  (f_negy),
        .o_coll   (f_coll),
        .o_ax     (f_ax),
        .o_ay     (f_ay)
    );

    cftp_div #(.Q_W(QW), .D_W(DM_W), .TAG_W(DTAG)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (f_vld),
        .i_num_x (QW'(f_nmx) << (FRAC_BITS + 1)),
        .i_num_y (QW'(f_nmy) << (FRAC_BITS + 1)),
        .i_den   (f_dmag),
        .i_tag   ({f_ax, f_ay, f_negx, f_negy, f_coll}),
        .o_valid (d_vld),
        .o_quo_x (d_qx),
        .o_quo_y (d_qy),
        .o_tag   (d_tag)
    );

    assign {d_ax, d_ay, d_negx, d_negy, d_coll} = d_tag;

    // Round the doubled quotient to nearest, then apply the sign.
    logic [QW:0]          w_incx, w_incy;
    logic [QW:0]          w_mx_z, w_my_z;
    logic                 r_p1_vld;
    logic signed [QW:0]   r_p1_ox, r_p1_oy;
    logic [QW-1:0]        r_p1_mx, r_p1_my;
    logic [C-1:0]         r_p1_ax, r_p1_ay;
    logic                 r_p1_coll;

    assign w_incx = (QW + 1)'(d_qx) + (QW + 1)'(1);
    assign w_incy = (QW + 1)'(d_qy) + (QW + 1)'(1);
    assign w_mx_z = {1'b0, w_incx[QW:1]};
    assign w_my_z = {1'b0, w_incy[QW:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else if (w_en) begin
            r_p1_vld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_ox   <= d_negx ? -$signed(w_mx_z) : $signed(w_mx_z);
            r_p1_oy   <= d_negy ? -$signed(w_my_z) : $signed(w_my_z);
            r_p1_mx   <= w_incx[QW:1];
            r_p1_my   <= w_incy[QW:1];
            r_p1_ax   <= d_ax;
            r_p1_ay   <= d_ay;
            r_p1_coll <= d_coll;
        end
    end

    // Center add and clip; squares of the offsets for the radius.
    logic signed [CE_W-1:0] w_oxe, w_oye, w_axe, w_aye, w_sx, w_sy;
    logic [M_W-1:0]         w_mxe, w_mye;
    logic [RAD_W-1:0]       w_lx, w_ly;
    logic [SQ_W-1:0]        w_qx, w_qy;
    t_fin_tag               n_p2_tag;
    logic                   r_p2_vld;
    logic [SQ_W-1:0]        r_p2_sqx, r_p2_sqy;
    t_fin_tag               r_p2_tag;

    assign w_oxe = r_p1_ox;
    assign w_oye = r_p1_oy;
    assign w_axe = $signed(CE_W'(r_p1_ax) << FRAC_BITS);
    assign w_aye = $signed(CE_W'(r_p1_ay) << FRAC_BITS);
    assign w_sx  = w_oxe + w_axe;
    assign w_sy  = w_oye + w_aye;
    assign w_mxe = M_W'(r_p1_mx);
    assign w_mye = M_W'(r_p1_my);
    assign w_lx  = w_mxe[RAD_W-1:0];
    assign w_ly  = w_mye[RAD_W-1:0];
    assign w_qx  = SQ_W'(w_lx) * SQ_W'(w_lx);
    assign w_qy  = SQ_W'(w_ly) * SQ_W'(w_ly);

    always_comb begin
        n_p2_tag.sat_c = 1'b0;
        if (w_sx > C_MAX) begin
            n_p2_tag.cx    = C_MAX[OUT_W-1:0];
            n_p2_tag.sat_c = 1'b1;
        end else if (w_sx < C_MIN) begin
            n_p2_tag.cx    = C_MIN[OUT_W-1:0];
            n_p2_tag.sat_c = 1'b1;
        end else begin
            n_p2_tag.cx = w_sx[OUT_W-1:0];
        end
        if (w_sy > C_MAX) begin
            n_p2_tag.cy    = C_MAX[OUT_W-1:0];
            n_p2_tag.sat_c = 1'b1;
        end else if (w_sy < C_MIN) begin
            n_p2_tag.cy    = C_MIN[OUT_W-1:0];
            n_p2_tag.sat_c = 1'b1;
        end else begin
            n_p2_tag.cy = w_sy[OUT_W-1:0];
        end
        n_p2_tag.big_r = ((w_mxe >> RAD_W) != '0) || ((w_mye >> RAD_W) != '0);
        n_p2_tag.coll  = r_p1_coll;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else if (w_en) begin
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2_sqx <= w_qx;
            r_p2_sqy <= w_qy;
            r_p2_tag <= n_p2_tag;
        end
    end

    // Sum of squares; a carry out means the radius is out of range.
    logic [SQ_W:0]   w_sum;
    t_fin_tag        n_p3_tag;
    logic            r_p3_vld;
    logic [SQ_W-1:0] r_p3_val;
    t_fin_tag        r_p3_tag;

    assign w_sum = {1'b0, r_p2_sqx} + {1'b0, r_p2_sqy};

    always_comb begin
        n_p3_tag       = r_p2_tag;
        n_p3_tag.big_r = r_p2_tag.big_r || w_sum[SQ_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_vld <= 1'b0;
        end else if (w_en) begin
            r_p3_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p3_val <= w_sum[SQ_W-1:0];
            r_p3_tag <= n_p3_tag;
        end
    end

    logic                 s_vld;
    logic [RAD_W-1:0]     s_root;
    logic [SQ_W-1:0]      s_rem;
    logic [FIN_TAG_W-1:0] s_tag_bits;
    t_fin_tag             s_tag;

    cftp_sqrt #(.TAG_W(FIN_TAG_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p3_vld),
        .i_val   (r_p3_val),
        .i_tag   (r_p3_tag),
        .o_valid (s_vld),
        .o_root  (s_root),
        .o_rem   (s_rem),
        .o_tag   (s_tag_bits)
    );

    assign s_tag = t_fin_tag'(s_tag_bits);

    // Round the root to nearest and build the result transaction.
    logic                    w_rnd, w_rsat;
    logic [RAD_W:0]          w_r33;
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_cx, r_out_cy;
    logic [RAD_W-1:0]        r_out_rad;
    logic                    r_out_coll, r_out_sat;

    assign w_rnd  = (s_rem > SQ_W'(s_root));
    assign w_r33  = (RAD_W + 1)'(s_root) + (RAD_W + 1)'(w_rnd);
    assign w_rsat = s_tag.big_r || w_r33[RAD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (s_tag.coll) begin
                r_out_cx   <= '0;
                r_out_cy   <= '0;
                r_out_rad  <= '0;
                r_out_coll <= 1'b1;
                r_out_sat  <= 1'b0;
            end else begin
                r_out_cx   <= s_tag.cx;
                r_out_cy   <= s_tag.cy;
                r_out_rad  <= w_rsat ? '1 : w_r33[RAD_W-1:0];
                r_out_coll <= 1'b0;
                r_out_sat  <= s_tag.sat_c || w_rsat;
            end
        end
    end

    assign o_circ.valid         = r_out_valid;
    assign o_circ.center_x      = r_out_cx;
    assign o_circ.center_y      = r_out_cy;
    assign o_circ.circle_radius = r_out_rad;
    assign o_circ.collinear     = r_out_coll;
    assign o_circ.saturated     = r_out_sat;

endmodule

>>> sv/cftp_checker.sv
// Port-level checks for circle_from_three_points, attached by a bind.
// Depends on cftp_pkg and the top level's interface ports.
`timescale 1ns / 1ps

module cftp_checker
    import cftp_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [OUT_W-1:0] i_center_x,
    input logic signed [OUT_W-1:0] i_center_y,
    input logic [RAD_W-1:0]        i_radius,
    input logic                    i_coll,
    input logic                    i_sat
);

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    a_ready_when_empty: assert property (@(posedge i_clk)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while the output is empty");

    a_coll_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_coll) |->
            (i_center_x == '0 && i_center_y == '0 && i_radius == '0 && !i_sat))
        else $error("collinear result with nonzero fields");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result transaction dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_center_x) && $stable(i_center_y) && $stable(i_radius)
             && $stable(i_coll) && $stable(i_sat)))
        else $error("result transaction changed while stalled");

endmodule

bind circle_from_three_points cftp_checker u_cftp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pts.valid),
    .i_in_ready  (i_pts.ready),
    .i_out_valid (o_circ.valid),
    .i_out_ready (o_circ.ready),
    .i_center_x  (o_circ.center_x),
    .i_center_y  (o_circ.center_y),
    .i_radius    (o_circ.circle_radius),
    .i_coll      (o_circ.collinear),
    .i_sat       (o_circ.saturated)
);
